// ===== sv/string_escape_quoter_top_defines.svh =====
// Assertion macros shared by the quoter modules
`ifndef STRING_ESCAPE_QUOTER_TOP_DEFINES_SVH
`define STRING_ESCAPE_QUOTER_TOP_DEFINES_SVH

// checked only outside reset
`define SEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/seq_pkg.sv =====
package seq_pkg;

    localparam int SEQ_MODE_W  = 2;
    localparam int SEQ_MAX_OUT = 8;
    localparam int SEQ_IDX_W   = 3;
    localparam int SEQ_Q_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [SEQ_MODE_W-1:0] {
        MODE_RAW  = 2'd0,
        MODE_PCT  = 2'd1,
        MODE_JSON = 2'd2,
        MODE_CSV  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_pay;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       closing_quote;
        logic       last_of_run;
    } t_out_pay;

    // one queued item: its expanded characters, index of the final one, close flag
    typedef struct packed {
        logic [SEQ_MAX_OUT-1:0][7:0] chars;
        logic [SEQ_IDX_W-1:0]        last_idx;
        logic                        closes;
    } t_entry;

endpackage

// ===== sv/seq_front.sv =====
module seq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  seq_pkg::t_in_pay                 i_data,
    input  logic                             i_cfg_we,
    input  logic [seq_pkg::SEQ_MODE_W-1:0]   i_cfg_wdata,
    input  logic                             i_full,
    output logic                             o_push,
    output seq_pkg::t_entry                  o_entry
);
    import seq_pkg::*;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [15:0][7:0] HEX_DIGITS = {
        8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    t_mode       r_mode;
    logic        r_inside;
    logic        n_inside;

    logic [7:0]  c;
    logic        is_zero;
    logic        open_q;
    logic        close_q;
    logic        acc;
    logic [7:0]  hex_hi;
    logic [7:0]  hex_lo;
    logic [7:0]  json_esc;
    logic [5:0][7:0] body;
    logic [2:0]  blen;
    logic [7:0][7:0] bext;
    logic [3:0]  total;

    assign c       = i_data.data_byte;
    assign is_zero = (c == 8'h00);
    assign open_q  = ~r_inside;
    assign close_q = is_zero | i_data.end_of_string;
    assign o_ready = ~i_full;
    assign acc     = i_valid & o_ready;
    assign o_push  = acc;
    assign hex_hi  = HEX_DIGITS[c[7:4]];
    assign hex_lo  = HEX_DIGITS[c[3:0]];

    always_comb begin
        case (c)
            8'h08:    json_esc = 8'h62;
            8'h0A:    json_esc = 8'h6E;
            8'h0D:    json_esc = 8'h72;
            8'h09:    json_esc = 8'h74;
            8'h0C:    json_esc = 8'h66;
            CH_QUOTE: json_esc = CH_QUOTE;
            CH_BSL:   json_esc = CH_BSL;
            CH_SLASH: json_esc = CH_SLASH;
            default:  json_esc = 8'h00;
        endcase
    end

    always_comb begin
        body = {6{CH_QUOTE}};
        blen = 3'd1;
        body[0] = c;
        case (r_mode)
            MODE_PCT: begin
                if (c < 8'h20 || c == CH_PCT || c == CH_QUOTE || c > 8'd126) begin
                    body[0] = CH_PCT;
                    body[1] = hex_hi;
                    body[2] = hex_lo;
                    blen    = 3'd3;
                end
            end
            MODE_JSON: begin
                if (json_esc != 8'h00) begin
                    body[0] = CH_BSL;
                    body[1] = json_esc;
                    blen    = 3'd2;
                end else if (c < 8'h20) begin
                    body[0] = CH_BSL;
                    body[1] = CH_U;
                    body[2] = CH_ZERO;
                    body[3] = CH_ZERO;
                    body[4] = hex_hi;
                    body[5] = hex_lo;
                    blen    = 3'd6;
                end
            end
            MODE_CSV: begin
                if (c == CH_QUOTE) begin
                    body[1] = CH_QUOTE;
                    blen    = 3'd2;
                end
            end
            default: begin
                blen = 3'd1;
            end
        endcase
        if (is_zero) begin
            blen = 3'd0;
        end
    end

    always_comb begin
        for (int j = 0; j < SEQ_MAX_OUT; j++) begin
            bext[j] = CH_QUOTE;
        end
        for (int j = 0; j < 6; j++) begin
            if (3'(j) < blen) begin
                bext[j] = body[j];
            end
        end
        o_entry.chars[0] = open_q ? CH_QUOTE : bext[0];
        for (int k = 1; k < SEQ_MAX_OUT; k++) begin
            o_entry.chars[k] = open_q ? bext[k-1] : bext[k];
        end
        total = {3'b000, open_q} + {1'b0, blen} + {3'b000, close_q};
        o_entry.last_idx = SEQ_IDX_W'(total - 4'd1);
        o_entry.closes   = close_q;
    end

    assign n_inside = ~close_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RAW;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_wdata);
            end
            if (acc) begin
                r_inside <= n_inside;
            end
        end
    end

`include "string_escape_quoter_top_defines.svh"

    `SEQ_ASSERT(a_close_leaves_string, (acc && close_q |=> !r_inside), "string left open after close")
    `SEQ_ASSERT(a_open_sets_inside, (acc && !close_q |=> r_inside), "string not open after byte")

endmodule

// ===== sv/seq_queue.sv =====
module seq_queue #(
    parameter int Q_DEPTH = seq_pkg::SEQ_Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  seq_pkg::t_entry i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output seq_pkg::t_entry o_rdata
);
    import seq_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry           r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "string_escape_quoter_top_defines.svh"

    `SEQ_ASSERT(a_count_bound, (r_count <= CNT_W'(Q_DEPTH)), "queue count over depth")
    `SEQ_ASSERT(a_no_pop_empty, (i_pop |-> !o_empty), "pop from empty queue")

endmodule

// ===== sv/seq_back.sv =====
module seq_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  seq_pkg::t_entry  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output seq_pkg::t_out_pay o_data
);
    import seq_pkg::*;

    logic [SEQ_IDX_W-1:0] r_idx;
    logic                 r_out_valid;
    t_out_pay             r_out;
    logic                 load;
    logic                 take;
    logic                 is_last;

    assign load    = ~r_out_valid | i_ready;
    assign take    = load & ~i_empty;
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = take & is_last;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= ~i_empty;
            end
            if (take) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_byte      <= i_head.chars[r_idx];
            r_out.closing_quote <= i_head.closes & is_last;
            r_out.last_of_run   <= is_last;
        end
    end

`include "string_escape_quoter_top_defines.svh"

    `SEQ_ASSERT(a_close_is_quote, (r_out_valid && r_out.closing_quote |-> r_out.out_byte == CH_QUOTE && r_out.last_of_run), "closing flag on wrong byte")
    `SEQ_ASSERT_ALWAYS(a_idx_needs_head, (r_idx != '0 |-> !i_empty), "index mid-item with empty queue")

endmodule

// ===== sv/string_escape_quoter_top.sv =====
// String quoter and escaper.
// Input channel i_valid/o_ready carries one source byte and its end mark per
// transfer; output channel o_valid/i_ready carries one output character per
// transfer, with closing_quote on the quote that closes a string and
// last_of_run on the final character caused by each input byte.
// i_cfg_we/i_cfg_wdata write the escape mode (raw, percent, JSON, CSV); write
// it only while no characters are pending.
// The first character of an input reaches o_data once the input transfer has
// been written into the queue and then registered by the output stage. Each
// input gives 1 to 8 characters; the output stage emits one character a cycle
// while i_ready is high, so plain text then flows at one byte a cycle.
// A small queue of expanded items sits between the classifier and the output
// sequencer; o_ready falls only when that queue is full.
// Reset (synchronous, active low) empties the queue, clears the output and
// closes any open string; the mode returns to raw.
// When the receiver stalls, the held character stays on o_data and the queue
// fills, after which input transfers stop.
module string_escape_quoter_top #(
    parameter int Q_DEPTH = seq_pkg::SEQ_Q_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  seq_pkg::t_in_pay               i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output seq_pkg::t_out_pay              o_data,
    input  logic                           i_cfg_we,
    input  logic [seq_pkg::SEQ_MODE_W-1:0] i_cfg_wdata
);
    import seq_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    t_entry wentry;
    t_entry head;

    seq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (wentry)
    );

    seq_queue #(
        .Q_DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wentry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (head)
    );

    seq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import seq_pkg::*;

    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    class escape_scoreboard;
        t_mode      mode = MODE_RAW;
        logic       in_string = 1'b0;
        t_out_pay   expected_chars[$];
        int         errors = 0;
        logic [7:0] run_ch[SEQ_MAX_OUT];
        logic       run_close[SEQ_MAX_OUT];
        int         run_len;

        function logic [7:0] hex_digit(logic [3:0] n);
            return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
        endfunction

        function void add(logic [7:0] ch, logic closing);
            run_ch[run_len] = ch;
            run_close[run_len] = closing;
            run_len++;
        endfunction

        function void add_hex(logic [7:0] c);
            add(hex_digit(c[7:4]), 1'b0);
            add(hex_digit(c[3:0]), 1'b0);
        endfunction

        function void add_escaped(logic [7:0] c);
            logic [7:0] esc;
            case (mode)
                MODE_PCT: begin
                    if (c < CH_SPACE || c == CH_PCT || c == CH_QUOTE || c > CH_TILDE) begin
                        add(CH_PCT, 1'b0);
                        add_hex(c);
                    end else begin
                        add(c, 1'b0);
                    end
                end
                MODE_JSON: begin
                    case (c)
                        8'h08:     esc = "b";
                        8'h0A:     esc = "n";
                        8'h0D:     esc = "r";
                        8'h09:     esc = "t";
                        8'h0C:     esc = "f";
                        CH_QUOTE:  esc = CH_QUOTE;
                        CH_BSLASH: esc = CH_BSLASH;
                        CH_SLASH:  esc = CH_SLASH;
                        default:   esc = CH_NUL;
                    endcase
                    if (esc != CH_NUL) begin
                        add(CH_BSLASH, 1'b0);
                        add(esc, 1'b0);
                    end else if (c < CH_SPACE) begin
                        add(CH_BSLASH, 1'b0);
                        add("u", 1'b0);
                        add("0", 1'b0);
                        add("0", 1'b0);
                        add_hex(c);
                    end else begin
                        add(c, 1'b0);
                    end
                end
                MODE_CSV: begin
                    add(c, 1'b0);
                    if (c == CH_QUOTE)
                        add(c, 1'b0);
                end
                default: add(c, 1'b0);
            endcase
        endfunction

        function void note_byte(t_in_pay p);
            t_out_pay r;
            run_len = 0;
            if (!in_string) begin
                add(CH_QUOTE, 1'b0);
                in_string = 1'b1;
            end
            if (p.data_byte == CH_NUL) begin
                add(CH_QUOTE, 1'b1);
                in_string = 1'b0;
            end else begin
                add_escaped(p.data_byte);
                if (p.end_of_string) begin
                    add(CH_QUOTE, 1'b1);
                    in_string = 1'b0;
                end
            end
            for (int i = 0; i < run_len; i++) begin
                r.out_byte      = run_ch[i];
                r.closing_quote = run_close[i];
                r.last_of_run   = (i == run_len - 1);
                expected_chars.push_back(r);
            end
        endfunction

        function int chars_pending();
            return expected_chars.size();
        endfunction

        task report(string what);
            if (errors < 40)
                $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_char(t_out_pay got);
            t_out_pay want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char %h", got.out_byte));
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_byte != want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.closing_quote != want.closing_quote)
                report($sformatf("closing_quote %b, want %b on %h",
                                 got.closing_quote, want.closing_quote, want.out_byte));
            if (got.last_of_run != want.last_of_run)
                report($sformatf("last_of_run %b, want %b on %h",
                                 got.last_of_run, want.last_of_run, want.out_byte));
        endtask

        task flush();
            if (expected_chars.size() != 0)
                report($sformatf("%0d chars never arrived", expected_chars.size()));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_ready;
    t_in_pay  src_data = '0;
    logic     dst_valid;
    logic     dst_ready = 1'b0;
    t_out_pay dst_data;
    logic     cfg_we = 1'b0;
    logic [SEQ_MODE_W-1:0] cfg_wdata = '0;

    int in_gap_max = 15;
    int out_gap_max = 15;
    int items_sent = 0;

    escape_scoreboard sb = new();

    string_escape_quoter_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (src_valid),
        .o_ready     (src_ready),
        .i_data      (src_data),
        .o_valid     (dst_valid),
        .i_ready     (dst_ready),
        .o_data      (dst_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        t_in_pay p;
        gap = $urandom_range(0, in_gap_max);
        p.data_byte = b;
        p.end_of_string = eos;
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= p;
        do @(posedge clk); while (!src_ready);
        sb.note_byte(p);
        items_sent++;
    endtask

    // only between transfers, once the output has drained
    task automatic set_mode(t_mode m);
        src_valid <= 1'b0;
        while (sb.chars_pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'($urandom_range(1, 31));
            1:       return CH_QUOTE;
            2:       return CH_PCT;
            3:       return CH_BSLASH;
            4:       return CH_SLASH;
            5:       return $urandom_range(0, 1) ? CH_TILDE : CH_DEL;
            6:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_string();
        int len;
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && $urandom_range(0, 1) == 1) begin
                send_byte(pick_byte(), 1'b1);
                return;
            end
            send_byte(pick_byte(), 1'b0);
        end
        send_byte(CH_NUL, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                dst_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            dst_ready <= 1'b1;
            do @(posedge clk); while (!dst_valid);
            sb.check_char(dst_data);
        end
    end

    initial begin
        t_mode phase_modes[8];
        int start;
        phase_modes = '{MODE_JSON, MODE_PCT, MODE_CSV, MODE_RAW,
                        MODE_RAW, MODE_CSV, MODE_PCT, MODE_JSON};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // raw mode straight out of reset: empty string, end mark, zero with mark
        send_byte(CH_NUL, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(CH_NUL, 1'b1);

        set_mode(MODE_PCT);
        send_byte(8'h1F, 1'b0);
        send_byte(CH_PCT, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(CH_TILDE, 1'b0);
        send_byte(CH_SPACE, 1'b1);

        set_mode(MODE_JSON);
        send_byte(8'h08, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_NUL, 1'b0);

        set_mode(MODE_CSV);
        send_byte(CH_QUOTE, 1'b1);
        send_byte(CH_NUL, 1'b0);

        for (int k = 0; k < 8; k++) begin
            case (k % 4)
                0: begin in_gap_max = 15; out_gap_max = 15; end
                1: begin in_gap_max = 0;  out_gap_max = 0;  end
                2: begin in_gap_max = 0;  out_gap_max = 15; end
                default: begin in_gap_max = 15; out_gap_max = 0; end
            endcase
            set_mode(phase_modes[k]);
            start = items_sent;
            while (items_sent - start < 48)
                send_string();
        end

        src_valid <= 1'b0;
        while (sb.chars_pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        sb.flush();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
